FILE: rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants
// Payload structs, mode codes and store width for the in-place radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int STORE_BITS = 28;
  localparam int POS_BITS   = 11;
  localparam int IN_BITS    = 16;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [POS_BITS-1:0]        position;
    logic signed [IN_BITS-1:0]  sample_re;
    logic signed [IN_BITS-1:0]  sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [STORE_BITS-1:0] bin_re;
    logic signed [STORE_BITS-1:0] bin_im;
  } out_item_t;

endpackage

FILE: rtl/r2fft_twiddle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_twiddle: twiddle ROM
// Registered cos/sin lookup over the first half circle, Q1.(TW-1), built at
// elaboration.
// ----------------------------------------------------------------------------
module r2fft_twiddle #(
  parameter int LOGN = 11,
  parameter int TW   = 16
) (
  input  logic                  clk,
  input  logic [LOGN-2:0]       idx,
  output logic signed [TW:0]    cos_q,
  output logic signed [TW:0]    sin_q
);

  localparam int HALF = 1 << (LOGN - 1);

  function automatic logic signed [TW:0] tw_val(input int k, input bit is_sin);
    real a;
    real v;
    real sc;
    a  = 6.283185307179586476 * k / (1 << LOGN);
    sc = 2.0 ** (TW - 1);
    v  = is_sin ? $sin(a) * sc : $cos(a) * sc;
    if (v >= 0.0) tw_val = (TW + 1)'($rtoi(v + 0.5));
    else tw_val = (TW + 1)'(-$rtoi(-v + 0.5));
  endfunction

  logic signed [TW:0] cos_rom [HALF];
  logic signed [TW:0] sin_rom [HALF];

  for (genvar k = 0; k < HALF; k++) begin : g_rom
    assign cos_rom[k] = tw_val(k, 1'b0);
    assign sin_rom[k] = tw_val(k, 1'b1);
  end

  always_ff @(posedge clk) begin
    cos_q <= cos_rom[idx];
    sin_q <= sin_rom[idx];
  end

endmodule

FILE: rtl/radix2_fft_in_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_in_place: in-place radix-2 DIT FFT
// Loads samples in bit-reversed order, runs all butterfly stages through one
// shared complex multiplier, and reads back bins.
// ----------------------------------------------------------------------------
// Usage: present an item on in_item with start high; it transfers when busy
// is low. Mode 0 (load) writes one sample. Mode 2 (read) gives one result
// on out_item with out_valid high for one cycle, once the read has passed
// the states S_RB1, S_RB2 and S_RB3; busy is high in those states. Mode 1
// (run) takes log2(POINTS) stages of POINTS/2 butterflies; each butterfly
// steps through S_RD_O, S_RD_E, S_MUL, S_WR_E and S_WR_O, using the single
// complex multiplier and the store's one read port and one write port.
// Mode 3 is dropped. The receiver cannot stall; each result is shown once.
// Reset clears the sequencer only; the store holds undefined data until
// written, so only loaded entries may be run or read.
// ----------------------------------------------------------------------------
module radix2_fft_in_place #(
  parameter int POINTS       = 2048,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  r2fft_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output r2fft_pkg::out_item_t  out_item
);

  localparam int LOGN = $clog2(POINTS + 1) - 1;
  localparam int N    = 1 << LOGN;
  localparam int SB   = r2fft_pkg::STORE_BITS;
  localparam int TW   = TWIDDLE_BITS;
  localparam int F    = TW - 1;
  localparam int SW   = $clog2(LOGN + 1);
  localparam int PW   = SB + TW + 2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD_O = 9'b000000010,
    S_RD_E = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_WR_E = 9'b000010000,
    S_WR_O = 9'b000100000,
    S_RB1  = 9'b001000000,
    S_RB2  = 9'b010000000,
    S_RB3  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2*SB-1:0] mem [N];
  logic [2*SB-1:0] rd_q;
  logic            we;
  logic [LOGN-1:0] waddr, raddr;
  logic [2*SB-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [LOGN-1:0] grp_r, grp_nxt;
  logic [SW-1:0]   st_r, st_nxt;
  logic [LOGN-1:0] pos_r;
  logic [LOGN-1:0] e_addr, o_addr, lowmask, tidx;
  logic [LOGN-2:0] k_part;

  always_comb begin
    lowmask = LOGN'((LOGN'(1) << st_r) - 1);
    k_part  = (LOGN-1)'(grp_r & lowmask);
    e_addr  = ((grp_r & ~lowmask) << 1) | LOGN'(k_part);
    o_addr  = e_addr | (LOGN'(1) << st_r);
    tidx    = LOGN'(k_part) << (LOGN - 1 - st_r);
  end

  logic signed [TW:0] cq, sq;
  r2fft_twiddle #(.LOGN(LOGN), .TW(TW)) u_tw (
    .clk(clk), .idx(tidx[LOGN-2:0]), .cos_q(cq), .sin_q(sq)
  );

  logic signed [SB-1:0] ar_r, ai_r;
  logic signed [PW-1:0] pr_r, pi_r;

  always_ff @(posedge clk) begin
    if (state_r == S_RD_E) begin
      ar_r <= rd_q[2*SB-1:SB];
      ai_r <= rd_q[SB-1:0];
    end
    if (state_r == S_MUL) begin
      pr_r <= PW'(ar_r * cq) + PW'(ai_r * sq) + (PW'(1) <<< (F - 1));
      pi_r <= PW'(ai_r * cq) - PW'(ar_r * sq) + (PW'(1) <<< (F - 1));
    end
  end

  function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    hi = PW'((64'sd1 <<< (SB - 1)) - 1);
    if (v > hi) sat = SB'(hi);
    else if (v < -hi - 1) sat = SB'(-hi - 1);
    else sat = SB'(v);
  endfunction

  logic signed [PW-1:0] pr_w, pi_w, er_w, ei_w;
  logic signed [SB-1:0] er_r, ei_r;
  always_comb begin
    pr_w = pr_r >>> F;
    pi_w = pi_r >>> F;
    er_w = PW'(er_r);
    ei_w = PW'(ei_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      er_r <= rd_q[2*SB-1:SB];
      ei_r <= rd_q[SB-1:0];
    end
  end

  logic signed [SB-1:0] sr, si;
  logic [LOGN-1:0]      pos_ext;
  logic [LOGN-1:0]      brev;
  always_comb begin
    pos_ext = LOGN'(in_item.position);
    for (int b = 0; b < LOGN; b++) brev[b] = pos_ext[LOGN-1-b];
    sr = SB'(signed'(in_item.sample_re[SAMPLE_BITS-1:0]));
    si = SB'(signed'(in_item.sample_im[SAMPLE_BITS-1:0]));
  end

  logic acc;
  assign acc  = start && !busy;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = e_addr;
    wdata = {er_r, ei_r};
    raddr = o_addr;
    state_nxt = state_r;
    grp_nxt = grp_r;
    st_nxt  = st_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_item.mode)
            r2fft_pkg::MODE_LOAD: begin
              we = 1'b1; waddr = brev; wdata = {sr, si};
            end
            r2fft_pkg::MODE_RUN: begin
              grp_nxt = '0; st_nxt = '0; state_nxt = S_RD_O;
            end
            r2fft_pkg::MODE_READ: state_nxt = S_RB1;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_O: begin raddr = o_addr; state_nxt = S_RD_E; end
      S_RD_E: begin raddr = e_addr; state_nxt = S_MUL; end
      S_MUL:  state_nxt = S_WR_E;
      S_WR_E: begin
        we = 1'b1; waddr = e_addr;
        wdata = {sat(er_w + pr_w), sat(ei_w + pi_w)};
        state_nxt = S_WR_O;
      end
      S_WR_O: begin
        we = 1'b1; waddr = o_addr;
        wdata = {sat(er_w - pr_w), sat(ei_w - pi_w)};
        if (grp_r == LOGN'(N / 2 - 1)) begin
          grp_nxt = '0;
          if (st_r == SW'(LOGN - 1)) state_nxt = S_IDLE;
          else begin st_nxt = st_r + 1'b1; state_nxt = S_RD_O; end
        end else begin
          grp_nxt = grp_r + 1'b1; state_nxt = S_RD_O;
        end
      end
      S_RB1: begin raddr = pos_r; state_nxt = S_RB2; end
      S_RB2: begin raddr = pos_r; state_nxt = S_RB3; end
      S_RB3: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic out_valid_r;
  r2fft_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      st_r        <= st_nxt;
      out_valid_r <= (state_r == S_RB3);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pos_r <= pos_ext;
    if (state_r == S_RB3) out_r <= {rd_q[2*SB-1:SB], rd_q[SB-1:0]};
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/r2fft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_checker: port-level checks
// Watches start/busy and the result strobe of the FFT top level.
// ----------------------------------------------------------------------------
module r2fft_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input r2fft_pkg::in_item_t  in_item,
  input logic                 out_valid
);

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == r2fft_pkg::MODE_READ) |=> busy)
    else $error("read transfer did not raise busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == r2fft_pkg::MODE_LOAD) |=> !busy)
    else $error("load transfer raised busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == r2fft_pkg::MODE_READ) |-> ##4 out_valid)
    else $error("read result missing");

endmodule

bind radix2_fft_in_place r2fft_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_item(in_item), .out_valid(out_valid)
);
